// ===== design/bba_pkg.sv =====
// Shared types, constants and helper functions for the buddy block allocator.
// No dependencies; imported by the top level and by bba_scan.
`timescale 1ns / 1ps

package bba_pkg;

  localparam int AddrBits  = 10;                  // pool address width
  localparam int MaxLevels = 10;                  // deepest tree level in use
  localparam int NodeBits  = AddrBits + 1;        // free-map node index width
  localparam int WordBits  = 32;                  // free-map bits per RAM row
  localparam int BitBits   = $clog2(WordBits);
  localparam int RowBits   = NodeBits - BitBits;
  localparam int Rows      = 2 ** RowBits;
  localparam int LvlBits   = 4;
  localparam int SizeBits  = AddrBits + 1;
  localparam int AlvDepth  = 2 ** AddrBits;

  localparam logic [LvlBits-1:0] TopReset = 4'd7;

  localparam logic [1:0] StOk       = 2'd0;
  localparam logic [1:0] StNoMem    = 2'd1;
  localparam logic [1:0] StBadAddr  = 2'd2;
  localparam logic [1:0] StBadSize  = 2'd3;

  typedef struct packed {
    logic                hit;
    logic [NodeBits-1:0] idx;
  } scan_res_t;

  // Effective top level: register value saturated at the deepest level.
  function automatic logic [LvlBits-1:0] eff_top(input logic [LvlBits-1:0] t);
    logic [LvlBits-1:0] lim;
    lim = LvlBits'(MaxLevels);
    return (t > lim) ? lim : t;
  endfunction

  // Tree node index of the block at level lvl starting at addr.
  function automatic logic [NodeBits-1:0] node_idx(input logic [LvlBits-1:0] lvl,
                                                  input logic [AddrBits-1:0] addr);
    logic [NodeBits:0] sum;
    sum = ((NodeBits+1)'(1) << (LvlBits'(AddrBits) - lvl))
        + ((NodeBits+1)'(addr) >> lvl);
    return sum[NodeBits-1:0];
  endfunction

  // Round a size up to a power of two and give its exponent (size 0 and 1 give 0).
  function automatic logic [LvlBits-1:0] ceil_log2(input logic [SizeBits-1:0] size);
    logic [SizeBits-1:0] s;
    logic [LvlBits-1:0]  x;
    s = size - SizeBits'(1);
    x = '0;
    for (int i = 0; i < SizeBits; i++) begin
      if (s[i]) x = LvlBits'(i + 1);
    end
    return (size == '0) ? '0 : x;
  endfunction

endpackage

// ===== design/buddy_block_allocator.sv =====
// Buddy block allocator top level: sequencer, free-map and level RAMs, row search.
// Depends on bba_pkg, bba_ram and bba_scan.
`timescale 1ns / 1ps

// A transaction is taken when start is high and busy is low; its single result
// appears on status/address/block_level for exactly one cycle with done high,
// and the receiver cannot stall it. The free-map RAM holds 32 tree nodes per
// row and is read and written one row at a time: allocate reads and checks
// each searched row (levels from the request's level upward, lowest address
// first), then takes the found node and frees one half per split level by
// read-modify-write, then writes the level RAM. Free reads the level RAM,
// tests the buddy per merge level, and marks the merged block free whether it
// has climbed to the top level or stops at a taken buddy; a free of an address
// that starts no allocated block answers after the level RAM read. Errors
// found from the request alone answer in the cycle after it. After reset and
// after every write of top_level the block clears both RAMs and is busy meanwhile.
module buddy_block_allocator (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         start,
  output logic                         busy,
  input  logic                         action,
  input  logic [bba_pkg::SizeBits-1:0] request_size,
  input  logic [bba_pkg::AddrBits-1:0] block_address,
  input  logic                         cfg_write,
  input  logic [bba_pkg::LvlBits-1:0]  cfg_data,
  output logic                         done,
  output logic [1:0]                   status,
  output logic [bba_pkg::AddrBits-1:0] address,
  output logic [bba_pkg::LvlBits-1:0]  block_level
);
  import bba_pkg::*;

  typedef enum logic [3:0] {
    S_IDLE, S_CLEAR, S_INIT, S_SCAN_RD, S_SCAN_CHK, S_RMW_RD, S_RMW_WR,
    S_ALV_WR, S_FR_CHK, S_MRG_TEST, S_MRG_RD, S_MRG_WR
  } state_t;

  state_t                state;
  logic [LvlBits-1:0]    top_level;
  logic [AddrBits-1:0]   cnt;
  logic [LvlBits-1:0]    cur_lvl;
  logic [LvlBits-1:0]    req_lvl;
  logic [RowBits-1:0]    scan_row;
  logic [AddrBits-1:0]   faddr;
  logic [AddrBits-1:0]   req_addr;
  logic [AddrBits-1:0]   merge_addr;
  logic [LvlBits-1:0]    orig_lvl;
  logic [NodeBits-1:0]   op_idx;
  logic                  op_val;
  logic                  is_free;

  logic [LvlBits-1:0]    eff_t;
  logic [LvlBits-1:0]    x_in;
  logic [LvlBits-1:0]    lvl_m1;
  logic [LvlBits-1:0]    lvl_p1;
  logic [NodeBits-1:0]   lo;
  logic [NodeBits-1:0]   lo_x;
  logic [NodeBits-1:0]   lo_next;
  logic [NodeBits:0]     hi_wide;
  logic [NodeBits-1:0]   hi;
  logic [NodeBits-1:0]   init_idx;
  logic [NodeBits-1:0]   split_idx;
  logic [NodeBits-1:0]   buddy_idx;
  logic [NodeBits-1:0]   merge_idx;
  logic [AddrBits-1:0]   found_addr;
  logic [AddrBits-1:0]   lvl_bit;
  logic [WordBits-1:0]   op_mask;
  logic                  op_bit;
  scan_res_t             scan;

  logic                  fm_we;
  logic [RowBits-1:0]    fm_waddr;
  logic [WordBits-1:0]   fm_wdata;
  logic [RowBits-1:0]    fm_raddr;
  logic [WordBits-1:0]   fm_rdata;
  logic                  al_we;
  logic [AddrBits-1:0]   al_waddr;
  logic [LvlBits-1:0]    al_wdata;
  logic [AddrBits-1:0]   al_raddr;
  logic [LvlBits-1:0]    al_rdata;

  assign busy       = (state != S_IDLE);
  assign eff_t      = eff_top(top_level);
  assign x_in       = ceil_log2(request_size);
  assign lvl_m1     = cur_lvl - LvlBits'(1);
  assign lvl_p1     = cur_lvl + LvlBits'(1);
  assign lo         = node_idx(cur_lvl, '0);
  assign lo_x       = node_idx(x_in, '0);
  assign lo_next    = node_idx(lvl_p1, '0);
  assign hi_wide    = (NodeBits+1)'(lo) + ((NodeBits+1)'(1) << (eff_t - cur_lvl))
                    - (NodeBits+1)'(1);
  assign hi         = hi_wide[NodeBits-1:0];
  assign init_idx   = node_idx(eff_t, '0);
  assign lvl_bit    = AddrBits'(1) << cur_lvl;
  assign split_idx  = node_idx(lvl_m1, faddr + (AddrBits'(1) << lvl_m1));
  assign buddy_idx  = node_idx(cur_lvl, merge_addr ^ lvl_bit);
  assign merge_idx  = node_idx(cur_lvl, merge_addr);
  assign found_addr = AddrBits'((scan.idx - lo) << cur_lvl);
  assign op_mask    = WordBits'(1) << op_idx[BitBits-1:0];
  assign op_bit     = fm_rdata[op_idx[BitBits-1:0]];

  bba_scan u_scan (
    .row_data (fm_rdata),
    .row      (scan_row),
    .lo       (lo),
    .hi       (hi),
    .res      (scan)
  );

  bba_ram #(.WIDTH(WordBits), .DEPTH(Rows)) u_free_map (
    .clk   (clk),
    .we    (fm_we),
    .waddr (fm_waddr),
    .wdata (fm_wdata),
    .raddr (fm_raddr),
    .rdata (fm_rdata)
  );

  bba_ram #(.WIDTH(LvlBits), .DEPTH(AlvDepth)) u_alloc_level (
    .clk   (clk),
    .we    (al_we),
    .waddr (al_waddr),
    .wdata (al_wdata),
    .raddr (al_raddr),
    .rdata (al_rdata)
  );

  // RAM port steering
  always_comb begin
    fm_we    = 1'b0;
    fm_waddr = op_idx[NodeBits-1:BitBits];
    fm_wdata = op_val ? (fm_rdata | op_mask) : (fm_rdata & ~op_mask);
    fm_raddr = (state == S_SCAN_RD) ? scan_row : op_idx[NodeBits-1:BitBits];
    al_we    = 1'b0;
    al_waddr = faddr;
    al_wdata = req_lvl + LvlBits'(1);
    al_raddr = block_address;
    case (state)
      S_CLEAR: begin
        fm_we    = (cnt[AddrBits-1:RowBits] == '0);
        fm_waddr = cnt[RowBits-1:0];
        fm_wdata = '0;
        al_we    = 1'b1;
        al_waddr = cnt;
        al_wdata = '0;
      end
      S_INIT: begin
        fm_we    = 1'b1;
        fm_waddr = init_idx[NodeBits-1:BitBits];
        fm_wdata = WordBits'(1) << init_idx[BitBits-1:0];
      end
      S_RMW_WR: fm_we = 1'b1;
      S_MRG_WR: begin
        fm_we    = op_bit;
        fm_wdata = fm_rdata & ~op_mask;
      end
      S_ALV_WR: al_we = 1'b1;
      S_FR_CHK: begin
        al_we    = (al_rdata != '0);
        al_waddr = req_addr;
        al_wdata = '0;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    done <= 1'b0;
    if (rst) begin
      state     <= S_CLEAR;
      top_level <= TopReset;
      cnt       <= '0;
    end else if (cfg_write) begin
      // new pool size: rebuild the pool from scratch
      top_level <= cfg_data;
      state     <= S_CLEAR;
      cnt       <= '0;
    end else begin
      case (state)
        S_CLEAR: begin
          cnt <= cnt + AddrBits'(1);
          if (cnt == '1) state <= S_INIT;
        end
        S_INIT: state <= S_IDLE;
        S_IDLE: begin
          if (start) begin
            req_addr <= block_address;
            req_lvl  <= x_in;
            cur_lvl  <= x_in;
            scan_row <= lo_x[NodeBits-1:BitBits];
            is_free  <= action;
            if (action) begin
              if ((AddrBits+1)'(block_address) >= ((AddrBits+1)'(1) << eff_t)) begin
                done        <= 1'b1;
                status      <= StBadAddr;
                address     <= '0;
                block_level <= '0;
              end else begin
                state <= S_FR_CHK;
              end
            end else if (request_size == '0) begin
              done        <= 1'b1;
              status      <= StBadSize;
              address     <= '0;
              block_level <= '0;
            end else if (x_in > eff_t) begin
              done        <= 1'b1;
              status      <= StNoMem;
              address     <= '0;
              block_level <= '0;
            end else begin
              state <= S_SCAN_RD;
            end
          end
        end
        S_SCAN_RD: state <= S_SCAN_CHK;
        S_SCAN_CHK: begin
          if (scan.hit) begin
            faddr  <= found_addr;
            op_idx <= scan.idx;
            op_val <= 1'b0;
            state  <= S_RMW_RD;
          end else if (scan_row != hi[NodeBits-1:BitBits]) begin
            scan_row <= scan_row + RowBits'(1);
            state    <= S_SCAN_RD;
          end else if (cur_lvl == eff_t) begin
            done        <= 1'b1;
            status      <= StNoMem;
            address     <= '0;
            block_level <= '0;
            state       <= S_IDLE;
          end else begin
            cur_lvl  <= lvl_p1;
            scan_row <= lo_next[NodeBits-1:BitBits];
            state    <= S_SCAN_RD;
          end
        end
        S_RMW_RD: state <= S_RMW_WR;
        S_RMW_WR: begin
          if (is_free) begin
            done        <= 1'b1;
            status      <= StOk;
            address     <= req_addr;
            block_level <= orig_lvl;
            state       <= S_IDLE;
          end else if (cur_lvl > req_lvl) begin
            // free the upper half one level down
            cur_lvl <= lvl_m1;
            op_idx  <= split_idx;
            op_val  <= 1'b1;
            state   <= S_RMW_RD;
          end else begin
            state <= S_ALV_WR;
          end
        end
        S_ALV_WR: begin
          done        <= 1'b1;
          status      <= StOk;
          address     <= faddr;
          block_level <= req_lvl;
          state       <= S_IDLE;
        end
        S_FR_CHK: begin
          if (al_rdata == '0) begin
            done        <= 1'b1;
            status      <= StBadAddr;
            address     <= '0;
            block_level <= '0;
            state       <= S_IDLE;
          end else begin
            orig_lvl   <= al_rdata - LvlBits'(1);
            cur_lvl    <= al_rdata - LvlBits'(1);
            merge_addr <= req_addr;
            state      <= S_MRG_TEST;
          end
        end
        S_MRG_TEST: begin
          if (cur_lvl < eff_t) begin
            op_idx <= buddy_idx;
            state  <= S_MRG_RD;
          end else begin
            op_idx <= merge_idx;
            op_val <= 1'b1;
            state  <= S_RMW_RD;
          end
        end
        S_MRG_RD: state <= S_MRG_WR;
        S_MRG_WR: begin
          if (op_bit) begin
            // buddy free: take it and climb
            merge_addr <= merge_addr & ~lvl_bit;
            cur_lvl    <= lvl_p1;
            state      <= S_MRG_TEST;
          end else begin
            op_idx <= merge_idx;
            op_val <= 1'b1;
            state  <= S_RMW_RD;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

// ===== design/bba_ram.sv =====
// Generic single-port-write, single-port-read RAM with registered read data.
// No dependencies.
`timescale 1ns / 1ps

module bba_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    rdata <= mem[raddr];
  end

endmodule

// ===== design/bba_scan.sv =====
// Free-map row search: lowest set node bit of one RAM row within a node range.
// Depends on bba_pkg.
`timescale 1ns / 1ps

module bba_scan (
  input  logic [bba_pkg::WordBits-1:0] row_data,
  input  logic [bba_pkg::RowBits-1:0]  row,
  input  logic [bba_pkg::NodeBits-1:0] lo,
  input  logic [bba_pkg::NodeBits-1:0] hi,
  output bba_pkg::scan_res_t           res
);
  import bba_pkg::*;

  logic [NodeBits-1:0] idx [WordBits];
  logic [WordBits-1:0] cand;

  always_comb begin
    for (int b = 0; b < WordBits; b++) begin
      idx[b]  = {row, BitBits'(b)};
      cand[b] = row_data[b] && (idx[b] >= lo) && (idx[b] <= hi);
    end
  end

  // Pick the lowest candidate: lowest node index is lowest address at a level.
  always_comb begin
    res.hit = |cand;
    res.idx = '0;
    for (int b = WordBits - 1; b >= 0; b--) begin
      if (cand[b]) res.idx = idx[b];
    end
  end

endmodule
